@@ hw/rtl/lgss_pkg.sv @@
package lgss_pkg;

    // Mode stepping defaults.
    localparam logic [3:0] LGSS_FIRST_MODE = 4'd4;
    localparam logic [3:0] LGSS_MODE_LIMIT = 4'd13;
    localparam logic [3:0] LGSS_RESET_MODE = 4'd5;

    // Mode boundaries of the light rules.
    localparam logic [3:0] LGSS_MODE_GAP_LIMIT  = 4'd5;
    localparam logic [3:0] LGSS_MODE_LIT_FIRST  = 4'd8;
    localparam logic [3:0] LGSS_MODE_DARK_FIRST = 4'd11;

    // Blink counts for tick items.
    localparam logic [3:0] LGSS_BLINK_NONE = 4'd0;
    localparam logic [3:0] LGSS_BLINK_DARK = 4'd1;
    localparam logic [3:0] LGSS_BLINK_LIT  = 4'd2;

    localparam int unsigned LGSS_CFG_W     = 32;
    localparam int unsigned LGSS_CFG_IDX_W = 3;
    localparam logic [15:0] LGSS_TIMER_MAX = 16'hFFFF;

    // Reset values of the configuration registers.
    localparam logic [31:0] LGSS_RST_THRESHOLD = 32'd50000;
    localparam logic [15:0] LGSS_RST_MIN_LIGHT = 16'd16;
    localparam logic [15:0] LGSS_RST_MAX_LIGHT = 16'd375;
    localparam logic [15:0] LGSS_RST_MIN_GAP   = 16'd94;
    localparam logic [15:0] LGSS_RST_P_SHORT   = 16'd375;
    localparam logic [15:0] LGSS_RST_P_MID     = 16'd1125;
    localparam logic [15:0] LGSS_RST_P_LONG    = 16'd2250;

    typedef enum logic [LGSS_CFG_IDX_W-1:0] {
        CFG_LIGHT_THRESHOLD = 3'd0,
        CFG_MIN_LIGHT_TICKS = 3'd1,
        CFG_MAX_LIGHT_TICKS = 3'd2,
        CFG_MIN_GAP_TICKS   = 3'd3,
        CFG_PERIOD_SHORT    = 3'd4,
        CFG_PERIOD_MID      = 3'd5,
        CFG_PERIOD_LONG     = 3'd6
    } t_cfg_idx;

    typedef enum logic {
        OP_TICK   = 1'b0,
        OP_BUTTON = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        PER_SHORT = 2'd0,
        PER_MID   = 2'd1,
        PER_LONG  = 2'd2
    } t_period_sel;

    typedef struct packed {
        logic [31:0] light_threshold;
        logic [15:0] min_light_ticks;
        logic [15:0] max_light_ticks;
        logic [15:0] min_gap_ticks;
        logic [15:0] period_short;
        logic [15:0] period_mid;
        logic [15:0] period_long;
    } t_cfg;

    typedef struct packed {
        t_opcode     opcode;
        logic [31:0] light_count;
        logic        spray_button;
        logic        mode_button;
    } t_item;

    typedef struct packed {
        logic [15:0] period_timer;
        logic [15:0] lit_ticks;
        logic [3:0]  mode;
    } t_state;

    typedef struct packed {
        logic       spray;
        logic [3:0] blink_count;
        logic       light_on;
        logic [3:0] current_mode;
    } t_result;

    // Period choice follows (mode - 1) mod 3; mode zero wraps to the short period.
    function automatic t_period_sel period_sel(input logic [3:0] mode);
        t_period_sel sel;
        case (mode) inside
            4'd1, 4'd4, 4'd7, 4'd10, 4'd13, 4'd0: sel = PER_SHORT;
            4'd2, 4'd5, 4'd8, 4'd11, 4'd14:       sel = PER_MID;
            default:                              sel = PER_LONG;
        endcase
        return sel;
    endfunction

    function automatic logic [15:0] sat_inc(input logic [15:0] value);
        return (value == LGSS_TIMER_MAX) ? value : value + 16'd1;
    endfunction

endpackage

@@ hw/rtl/light_gated_spray_scheduler.sv @@
// Light-gated spray scheduler.
// Input channel (i_in_valid / o_in_stall) carries one item: a tick with a
// light-sensor count, or a button event with the spray and mode buttons.
// Output channel (o_out_valid / i_out_stall) returns exactly one result per
// item: spray decision, blink count, light judgement and the mode after it.
// An item is taken at a clock edge with valid high and stall low.
// The item is captured in an input register, evaluated combinationally against
// the timers and mode, and its result lands in the output register, where it
// is offered and can be taken at a clock edge with i_out_stall low. One item
// per cycle is taken for as long as the output side keeps up; the single
// compare-and-update step between the two registers sets that rate.
// When the receiver stalls, the result waits in the output register, the
// next item waits in the input register, and o_in_stall rises only once both
// are full. Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) are to be
// made by the user while no item is in flight; the block does not enforce this.
// Synchronous active-low reset empties both registers, clears the timers, sets
// the mode to RESET_MODE and loads the default configuration.
module light_gated_spray_scheduler
    import lgss_pkg::*;
#(
    parameter logic [3:0] FIRST_MODE = LGSS_FIRST_MODE,
    parameter logic [3:0] MODE_LIMIT = LGSS_MODE_LIMIT,
    parameter logic [3:0] RESET_MODE = LGSS_RESET_MODE
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_opcode,
    input  logic [31:0]               i_light_count,
    input  logic                      i_spray_button,
    input  logic                      i_mode_button,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_spray,
    output logic [3:0]                o_blink_count,
    output logic                      o_light_on,
    output logic [3:0]                o_current_mode,
    input  logic                      i_cfg_we,
    input  logic [LGSS_CFG_IDX_W-1:0] i_cfg_index,
    input  logic [LGSS_CFG_W-1:0]     i_cfg_data
);

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_item   r_item;
    t_result r_result;
    t_result n_result;
    logic    r_in_valid;
    logic    r_out_valid;
    logic    out_free;
    logic    advance;
    logic    in_take;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    lgss_step #(
        .FIRST_MODE(FIRST_MODE),
        .MODE_LIMIT(MODE_LIMIT)
    ) u_step (
        .i_item   (r_item),
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.light_threshold <= LGSS_RST_THRESHOLD;
            r_cfg.min_light_ticks <= LGSS_RST_MIN_LIGHT;
            r_cfg.max_light_ticks <= LGSS_RST_MAX_LIGHT;
            r_cfg.min_gap_ticks   <= LGSS_RST_MIN_GAP;
            r_cfg.period_short    <= LGSS_RST_P_SHORT;
            r_cfg.period_mid      <= LGSS_RST_P_MID;
            r_cfg.period_long     <= LGSS_RST_P_LONG;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LIGHT_THRESHOLD: r_cfg.light_threshold <= i_cfg_data;
                CFG_MIN_LIGHT_TICKS: r_cfg.min_light_ticks <= i_cfg_data[15:0];
                CFG_MAX_LIGHT_TICKS: r_cfg.max_light_ticks <= i_cfg_data[15:0];
                CFG_MIN_GAP_TICKS:   r_cfg.min_gap_ticks   <= i_cfg_data[15:0];
                CFG_PERIOD_SHORT:    r_cfg.period_short    <= i_cfg_data[15:0];
                CFG_PERIOD_MID:      r_cfg.period_mid      <= i_cfg_data[15:0];
                CFG_PERIOD_LONG:     r_cfg.period_long     <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.period_timer <= 16'd0;
            r_state.lit_ticks    <= 16'd0;
            r_state.mode         <= RESET_MODE;
            r_in_valid           <= 1'b0;
            r_out_valid          <= 1'b0;
        end else begin
            if (advance) begin
                r_state <= n_state;
            end
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item.opcode       <= t_opcode'(i_opcode);
            r_item.light_count  <= i_light_count;
            r_item.spray_button <= i_spray_button;
            r_item.mode_button  <= i_mode_button;
        end
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_spray        = r_result.spray;
    assign o_blink_count  = r_result.blink_count;
    assign o_light_on     = r_result.light_on;
    assign o_current_mode = r_result.current_mode;

`ifndef NO_ASSERTIONS
    a_reset_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> (r_state.mode == RESET_MODE))
        else $error("mode not at reset value after reset");

    a_lit_blink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_light_on) |-> (o_blink_count == LGSS_BLINK_LIT))
        else $error("lit tick result without lit blink count");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid))
        else $error("input stalled while a register is free");
`endif

endmodule

@@ hw/rtl/lgss_step.sv @@
module lgss_step
    import lgss_pkg::*;
#(
    parameter logic [3:0] FIRST_MODE = LGSS_FIRST_MODE,
    parameter logic [3:0] MODE_LIMIT = LGSS_MODE_LIMIT
) (
    input  t_item   i_item,
    input  t_state  i_state,
    input  t_cfg    i_cfg,
    output t_state  o_state,
    output t_result o_result
);

    logic [15:0] period;
    logic [15:0] pt_inc;
    logic [15:0] pt_after_period;
    logic [15:0] lt_inc;
    logic        lit;
    logic        period_hit;
    logic        period_spray;
    logic        off_spray;
    logic [3:0]  mode;
    logic [3:0]  next_mode;

    assign mode = i_state.mode;

    always_comb begin
        case (period_sel(mode))
            PER_SHORT: period = i_cfg.period_short;
            PER_MID:   period = i_cfg.period_mid;
            default:   period = i_cfg.period_long;
        endcase
    end

    assign lit        = i_item.light_count < i_cfg.light_threshold;
    assign pt_inc     = sat_inc(i_state.period_timer);
    assign lt_inc     = sat_inc(i_state.lit_ticks);
    assign period_hit = (mode != 4'd0) && (pt_inc >= period);

    // The period timer restarts on every hit, whether or not the light rule lets the motor run.
    assign pt_after_period = period_hit ? 16'd0 :
                             (pt_inc > i_cfg.period_long) ? i_cfg.period_long : pt_inc;

    always_comb begin
        period_spray = 1'b0;
        if (mode < LGSS_MODE_LIT_FIRST) begin
            period_spray = !lit || (i_state.lit_ticks >= i_cfg.max_light_ticks);
        end else if (mode < LGSS_MODE_DARK_FIRST) begin
            period_spray = lit;
        end else begin
            period_spray = !lit;
        end
        period_spray = period_spray && period_hit;
    end

    // A light-on spell that just ended may trigger a spray in the low modes.
    assign off_spray = (mode < LGSS_MODE_GAP_LIMIT)
                       && (i_state.lit_ticks > i_cfg.min_light_ticks)
                       && (pt_after_period > i_cfg.min_gap_ticks);

    always_comb begin
        next_mode = mode + 4'd1;
        if (next_mode == MODE_LIMIT) begin
            next_mode = FIRST_MODE;
        end
    end

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        if (i_item.opcode == OP_TICK) begin
            o_result.light_on = lit;
            if (lit) begin
                o_result.spray       = period_spray;
                o_result.blink_count = LGSS_BLINK_LIT;
                o_state.period_timer = pt_after_period;
                o_state.lit_ticks    = (lt_inc > i_cfg.max_light_ticks) ?
                                       i_cfg.max_light_ticks : lt_inc;
            end else begin
                o_result.spray       = period_spray || off_spray;
                o_result.blink_count = off_spray ? LGSS_BLINK_NONE : LGSS_BLINK_DARK;
                o_state.period_timer = off_spray ? 16'd0 : pt_after_period;
                o_state.lit_ticks    = 16'd0;
            end
        end else begin
            if (i_item.spray_button) begin
                o_result.spray       = 1'b1;
                o_state.period_timer = 16'd0;
            end
            if (i_item.mode_button) begin
                o_state.mode         = next_mode;
                o_state.period_timer = 16'd0;
                o_state.lit_ticks    = 16'd0;
                o_result.blink_count = next_mode - FIRST_MODE + 4'd1;
            end
        end
        o_result.current_mode = o_state.mode;
    end

endmodule
